>>> hdl/orot_pkg.sv
// orot_pkg: shared widths, sequencer control types and the axis corner table
// for the oriented rectangle overlap test; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package orot_pkg;

  localparam int COORD_WIDTH = 32;                 // stored world coordinate width
  localparam int IN_W        = 32;                 // width of each input coordinate field
  localparam int FRAC_W      = 16;                 // Q16.16 fraction bits
  localparam int MUL_W       = IN_W + 1;           // shared multiplier operand width
  localparam int PROD_W      = 2 * MUL_W;          // full product width
  localparam int SUM_W       = PROD_W + 1;         // dot product / scaled sum width
  localparam int AX_W        = COORD_WIDTH + 1;    // axis component width
  localparam int NUM_SLOTS   = 8;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int NUM_AXES    = 4;
  localparam int AXIS_W      = $clog2(NUM_AXES);

  localparam logic [NUM_SLOTS-1:0] MASK_FULL = '1;

  typedef enum logic [2:0] {
    MOP_IDLE,
    MOP_LX,    // local_x * scale_x
    MOP_LY,    // local_y * scale_y
    MOP_PX,    // corner x * axis x
    MOP_PY     // corner y * axis y
  } mul_op_t;

  typedef struct packed {
    mul_op_t           mul_op;
    logic [SLOT_W-1:0] rd_addr;
    logic              ax_load;
    logic              ax_sub;
    logic              wx_en;
    logic              wr_en;
    logic              start;
    logic              upd;
    logic              upd_first;
    logic              upd_shape;
    logic              chk;
    logic              res_load;
  } ctrl_t;

  typedef struct packed {
    logic last;
    logic mask_full;
    logic out_free;
  } status_t;

  // axis = corner a minus corner b; second rectangle corners sit at slot + 4
  function automatic logic [SLOT_W-1:0] axis_src(input logic [AXIS_W-1:0] ax,
                                                 input logic sel_b);
    logic [SLOT_W-1:0] a, b;
    begin
      unique case (ax)
        2'd0: begin a = 3'd0; b = 3'd1; end  // ur - ul, first
        2'd1: begin a = 3'd0; b = 3'd2; end  // ur - lr, first
        2'd2: begin a = 3'd6; b = 3'd4; end  // lr - ur, second
        default: begin a = 3'd5; b = 3'd4; end  // ul - ur, second
      endcase
      return sel_b ? b : a;
    end
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi, lo;
    begin
      hi = (SUM_W'(signed'(1)) <<< (COORD_WIDTH - 1)) - SUM_W'(signed'(1));
      lo = -hi - SUM_W'(signed'(1));
      if (v > hi) return hi[COORD_WIDTH-1:0];
      else if (v < lo) return lo[COORD_WIDTH-1:0];
      else return v[COORD_WIDTH-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> hdl/orot_mul.sv
// orot_mul: shared signed multiplier with a registered product
// depends on orot_pkg
`timescale 1ns / 1ps
`default_nettype none

module orot_mul (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [orot_pkg::MUL_W-1:0]  op_a,
  input  wire logic signed [orot_pkg::MUL_W-1:0]  op_b,
  output logic signed [orot_pkg::PROD_W-1:0]      prod_r
);
  import orot_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

endmodule

`default_nettype wire

>>> hdl/orot_seq.sv
// orot_seq: sequencer for corner loading and the four-axis projection test
// depends on orot_pkg
`timescale 1ns / 1ps
`default_nettype none

module orot_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire orot_pkg::status_t sts,
  output logic                   idle,
  output orot_pkg::ctrl_t        ctrl
);
  import orot_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LX, S_LY, S_LW, S_DEC, S_AXA, S_AXB, S_PX, S_PY, S_PFIN, S_CHK, S_RES
  } state_t;

  state_t            state_r;
  logic [AXIS_W-1:0] ax_r;
  logic [SLOT_W-1:0] k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ax_r    <= '0;
      k_r     <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_fire) state_r <= S_LX;
        S_LX:   state_r <= S_LY;
        S_LY:   state_r <= S_LW;
        S_LW:   state_r <= sts.last ? S_DEC : S_IDLE;
        S_DEC: begin
          ax_r    <= '0;
          state_r <= sts.mask_full ? S_AXA : S_RES;
        end
        S_AXA:  state_r <= S_AXB;
        S_AXB: begin
          k_r     <= '0;
          state_r <= S_PX;
        end
        S_PX:   state_r <= S_PY;
        S_PY: begin
          k_r     <= k_r + SLOT_W'(1);
          state_r <= (k_r == SLOT_W'(NUM_SLOTS - 1)) ? S_PFIN : S_PX;
        end
        S_PFIN: state_r <= S_CHK;
        S_CHK: begin
          ax_r    <= ax_r + AXIS_W'(1);
          state_r <= (ax_r == AXIS_W'(NUM_AXES - 1)) ? S_RES : S_AXA;
        end
        S_RES:  if (sts.out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ctrl           = '0;
    ctrl.mul_op    = MOP_IDLE;
    ctrl.rd_addr   = k_r;
    ctrl.upd_first = (k_r[1:0] == 2'd0);
    ctrl.upd_shape = k_r[SLOT_W-1];
    idle           = (state_r == S_IDLE);
    unique case (state_r)
      S_LX:  ctrl.mul_op = MOP_LX;
      S_LY: begin
        ctrl.mul_op = MOP_LY;
        ctrl.wx_en  = 1'b1;
      end
      S_LW:  ctrl.wr_en = 1'b1;
      S_DEC: ctrl.start = 1'b1;
      S_AXA: begin
        ctrl.rd_addr = axis_src(ax_r, 1'b0);
        ctrl.ax_load = 1'b1;
      end
      S_AXB: begin
        ctrl.rd_addr = axis_src(ax_r, 1'b1);
        ctrl.ax_sub  = 1'b1;
      end
      S_PX:  ctrl.mul_op = MOP_PX;
      S_PY: begin
        ctrl.mul_op = MOP_PY;
        ctrl.upd    = 1'b1;
      end
      S_CHK: ctrl.chk = 1'b1;
      S_RES: ctrl.res_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/oriented_rect_overlap_test.sv
// oriented_rect_overlap_test: top level with corner store, axis and min/max
// registers and result register; depends on orot_pkg, orot_mul, orot_seq
//
// channel | dir | tdata                              | tuser                | tlast
// in_     | in  | local_x,local_y,scale_x/y,pos_x/y  | which_shape, corner  | last
// out_    | out | collides (zero padded to 8 bits)   | incomplete           | -
//
// a load item runs two products on the shared multiplier, then the saturating
// add and store; an item with tlast adds a decision step and, with all eight
// corners loaded, a projection of each of the 4 axes (16 products per axis on
// the one shared multiplier) before the result is handed over.
// reset returns the sequencer to idle and clears the loaded-corner mask and the
// output valid; stored corners are left as they are.
// a result waiting on out_tready holds the next item that carries tlast in its
// hand-over cycle, and the input stays not ready until that result leaves.
`timescale 1ns / 1ps
`default_nettype none

module oriented_rect_overlap_test (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // local_x, local_y, scale_x, scale_y, pos_x, pos_y (32 bits each)
  input  wire logic [191:0] in_tdata,
  // which_shape, corner[1:0]
  input  wire logic [2:0]   in_tuser,
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // collides, 7 zero bits
  output logic [7:0]        out_tdata,
  // incomplete
  output logic [0:0]        out_tuser
);
  import orot_pkg::*;

  logic    in_fire;
  logic    idle;
  ctrl_t   ctrl;
  status_t sts;

  // captured item
  logic [SLOT_W-1:0]      slot_r;
  logic signed [IN_W-1:0] lx_r, ly_r, sx_r, sy_r, px_r, py_r;
  logic                   last_r;

  logic [2*COORD_WIDTH-1:0]      corners [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]          mask_r;
  logic signed [COORD_WIDTH-1:0] wx_r, wy;
  logic signed [COORD_WIDTH-1:0] rd_x, rd_y;

  logic signed [AX_W-1:0]   ax_r, ay_r;
  logic signed [MUL_W-1:0]  op_a, op_b;
  logic                     mul_en;
  logic signed [PROD_W-1:0] prod_r, acc_r;

  logic                    upd_r, upd_first_r, upd_shape_r;
  logic signed [SUM_W-1:0] dotv;
  logic signed [SUM_W-1:0] mn_r [2];
  logic signed [SUM_W-1:0] mx_r [2];
  logic                    hit_r;
  logic                    overlap;

  logic out_tvalid_r, out_col_r, out_inc_r;

  assign in_tready = idle;
  assign in_fire   = in_tvalid & in_tready;

  assign sts.last      = last_r;
  assign sts.mask_full = (mask_r == MASK_FULL);
  assign sts.out_free  = !out_tvalid_r || out_tready;

  orot_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .sts     (sts),
    .idle    (idle),
    .ctrl    (ctrl)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      slot_r <= {in_tuser[0], in_tuser[2:1]};
      lx_r   <= in_tdata[31:0];
      ly_r   <= in_tdata[63:32];
      sx_r   <= in_tdata[95:64];
      sy_r   <= in_tdata[127:96];
      px_r   <= in_tdata[159:128];
      py_r   <= in_tdata[191:160];
      last_r <= in_tlast;
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    op_a   = '0;
    op_b   = '0;
    unique case (ctrl.mul_op)
      MOP_LX: begin
        op_a = MUL_W'(lx_r);
        op_b = MUL_W'(sx_r);
      end
      MOP_LY: begin
        op_a = MUL_W'(ly_r);
        op_b = MUL_W'(sy_r);
      end
      MOP_PX: begin
        op_a = MUL_W'(rd_x);
        op_b = MUL_W'(ax_r);
      end
      MOP_PY: begin
        op_a = MUL_W'(rd_y);
        op_b = MUL_W'(ay_r);
      end
      default: mul_en = 1'b0;
    endcase
  end

  orot_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // arithmetic shift is floor division by 2^16
  assign wy = sat_coord(SUM_W'(prod_r >>> FRAC_W) + SUM_W'(py_r));

  always_ff @(posedge clk) begin
    if (ctrl.wx_en) begin
      wx_r <= sat_coord(SUM_W'(prod_r >>> FRAC_W) + SUM_W'(px_r));
    end
    if (ctrl.wr_en) begin
      corners[slot_r] <= {wy, wx_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (ctrl.wr_en) begin
      mask_r <= mask_r | (NUM_SLOTS'(1) << slot_r);
    end
  end

  assign rd_x = corners[ctrl.rd_addr][COORD_WIDTH-1:0];
  assign rd_y = corners[ctrl.rd_addr][2*COORD_WIDTH-1:COORD_WIDTH];

  always_ff @(posedge clk) begin
    if (ctrl.ax_load) begin
      ax_r <= AX_W'(rd_x);
      ay_r <= AX_W'(rd_y);
    end else if (ctrl.ax_sub) begin
      ax_r <= ax_r - AX_W'(rd_x);
      ay_r <= ay_r - AX_W'(rd_y);
    end
  end

  // x product parks in acc_r while y is multiplied; upd_r marks the next cycle, when the sum is formed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_r <= 1'b0;
    end else begin
      upd_r <= ctrl.upd;
    end
    if (ctrl.upd) begin
      acc_r       <= prod_r;
      upd_first_r <= ctrl.upd_first;
      upd_shape_r <= ctrl.upd_shape;
    end
  end

  assign dotv = SUM_W'(acc_r) + SUM_W'(prod_r);

  always_ff @(posedge clk) begin
    if (upd_r) begin
      if (upd_first_r || (dotv <= mn_r[upd_shape_r])) mn_r[upd_shape_r] <= dotv;
      if (upd_first_r || (mx_r[upd_shape_r] <= dotv)) mx_r[upd_shape_r] <= dotv;
    end
  end

  // touching intervals count as overlapping
  assign overlap = (mn_r[1] <= mx_r[0]) && (mn_r[0] <= mx_r[1]);

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      hit_r <= 1'b1;
    end else if (ctrl.chk) begin
      hit_r <= hit_r & overlap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctrl.res_load) begin
      out_tvalid_r <= 1'b1;
      out_col_r    <= sts.mask_full & hit_r;
      out_inc_r    <= !sts.mask_full;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_col_r};
  assign out_tuser  = out_inc_r;

endmodule

`default_nettype wire
